/* sv/oal_pkg.sv */
`timescale 1ns / 1ps

package oal_pkg;

    // list geometry
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 8;
    localparam int DATA_W   = 32;

    typedef logic [1:0]               opcode_t;
    typedef logic [1:0]               status_t;
    typedef logic [7:0]               position_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic signed [DATA_W-1:0] data_t;

    // request opcodes
    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_DELETE = 2'd1;
    localparam opcode_t OP_GET    = 2'd2;
    localparam opcode_t OP_LOCATE = 2'd3;

    // result status codes
    localparam status_t ST_OK           = 2'd0;
    localparam status_t ST_BAD_POSITION = 2'd1;
    localparam status_t ST_FULL         = 2'd2;

endpackage

/* sv/oal_req_if.sv */
`timescale 1ns / 1ps

interface oal_req_if;
    import oal_pkg::*;

    logic      valid;
    logic      ready;
    opcode_t   opcode;
    position_t position;
    data_t     item_value;

    modport source (output valid, output opcode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input item_value,
                    output ready);
endinterface

/* sv/oal_rsp_if.sv */
`timescale 1ns / 1ps

interface oal_rsp_if;
    import oal_pkg::*;

    logic      valid;
    logic      ready;
    status_t   status;
    data_t     read_value;
    position_t found_position;
    count_t    list_length;

    modport source (output valid, output status, output read_value,
                    output found_position, output list_length, input ready);
    modport sink   (input valid, input status, input read_value,
                    input found_position, input list_length, output ready);
endinterface

/* sv/oal_ram.sv */
`timescale 1ns / 1ps

module oal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/ordered_array_list_engine.sv */
// Insert, delete and locate walk the stored entries through the single read port
// of the entry RAM, one entry per cycle; a rejected request skips the walk.
// The next request is taken in the cycle after the result of the one before is
// loaded into the output register; a new one is taken while that result waits.
// Reset clears the length and control state; the entry RAM is not cleared.
`timescale 1ns / 1ps

module ordered_array_list_engine (
    input  logic clk,
    input  logic rst_n,
    oal_req_if.sink   req,
    oal_rsp_if.source rsp
);
    import oal_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WFIN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    count_t            count_reg, count_next;
    count_t            rem_reg, rem_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] prev_reg, prev_next;
    logic              pend_reg, pend_next;
    opcode_t           op_reg, op_next;
    position_t         pos_reg, pos_next;
    data_t             val_reg, val_next;
    status_t           res_status_reg, res_status_next;
    data_t             res_read_reg, res_read_next;
    count_t            res_found_reg, res_found_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    data_t             out_read_reg, out_read_next;
    count_t            out_found_reg, out_found_next;
    count_t            out_length_reg, out_length_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    data_t             ram_wdata;
    logic              ram_re;
    data_t             ram_rdata;

    logic [CNT_W:0]    count_plus1;
    logic              pos_zero;
    logic              ins_pos_ok;
    logic              pos_ok;
    logic              accept;
    logic              issue;

    oal_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ptr_reg),
        .rd_data (ram_rdata)
    );

    // request position checks
    assign count_plus1 = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign pos_zero    = (req.position == '0);
    assign ins_pos_ok  = !pos_zero && ({1'b0, req.position} <= count_plus1);
    assign pos_ok      = !pos_zero && (req.position <= count_reg);

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign issue     = (rem_reg != '0);
    assign ram_re    = (state_reg == ST_RUN) && issue;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        ptr_next        = ptr_reg;
        prev_next       = prev_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_read_next   = out_read_reg;
        out_found_next  = out_found_reg;
        out_length_next = out_length_reg;
        ram_we          = 1'b0;
        ram_waddr       = prev_reg;
        ram_wdata       = ram_rdata;

        // output register drains independently
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.opcode;
                    pos_next        = req.position;
                    val_next        = req.item_value;
                    res_status_next = ST_OK;
                    res_read_next   = '0;
                    res_found_next  = '0;
                    pend_next       = 1'b0;
                    state_next      = ST_RUN;
                    unique case (req.opcode)
                        OP_INSERT:
                        begin
                            if (!ins_pos_ok)
                            begin
                                res_status_next = ST_BAD_POSITION;
                                state_next      = ST_DONE;
                            end
                            else if (count_reg == count_t'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = ST_DONE;
                            end
                            rem_next = count_t'(count_plus1 - {1'b0, req.position});
                            ptr_next = ADDR_W'(count_reg - count_t'(1));
                        end
                        OP_DELETE:
                        begin
                            if (!pos_ok)
                            begin
                                res_status_next = ST_BAD_POSITION;
                                state_next      = ST_DONE;
                            end
                            rem_next = count_reg - req.position;
                            ptr_next = ADDR_W'(req.position);
                        end
                        OP_GET:
                        begin
                            if (!pos_ok)
                            begin
                                res_status_next = ST_BAD_POSITION;
                                state_next      = ST_DONE;
                            end
                            rem_next = count_t'(1);
                            ptr_next = ADDR_W'(req.position - position_t'(1));
                        end
                        default:
                        begin
                            rem_next = count_reg;
                            ptr_next = '0;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                // launch the next read
                if (issue)
                begin
                    rem_next  = rem_reg - count_t'(1);
                    prev_next = ptr_reg;
                    pend_next = 1'b1;
                    ptr_next  = (op_reg == OP_INSERT) ? ptr_reg - ADDR_W'(1)
                                                      : ptr_reg + ADDR_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // consume the read that returned this cycle
                if (pend_reg)
                begin
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = prev_reg + ADDR_W'(1);
                        end
                        OP_DELETE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = prev_reg - ADDR_W'(1);
                        end
                        OP_GET:
                        begin
                            res_read_next = ram_rdata;
                            state_next    = ST_DONE;
                        end
                        default:
                        begin
                            if (ram_rdata == val_reg)
                            begin
                                res_found_next = count_t'({1'b0, prev_reg} + 1'b1);
                                state_next     = ST_DONE;
                            end
                        end
                    endcase
                end
                else if (!issue)
                begin
                    // walk finished
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            state_next = ST_WFIN;
                        end
                        OP_DELETE:
                        begin
                            count_next = count_reg - count_t'(1);
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_WFIN:
            begin
                // place the new value in the opened slot
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'(pos_reg - position_t'(1));
                ram_wdata  = val_reg;
                count_next = count_reg + count_t'(1);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_read_next   = res_read_reg;
                    out_found_next  = res_found_reg;
                    out_length_next = count_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        ptr_reg        <= ptr_next;
        prev_reg       <= prev_next;
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_read_reg   <= out_read_next;
        out_found_reg  <= out_found_next;
        out_length_reg <= out_length_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.read_value     = out_read_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.list_length    = out_length_reg;

    // length never exceeds the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("list length above capacity");

    // length moves by one at most per request
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + count_t'(1) ||
             count_reg == $past(count_reg) - count_t'(1)))
        else $error("list length jumped");

    // the store is written only while a request is being worked
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_RUN || state_reg == ST_WFIN))
        else $error("store written outside a request");

    // a fresh result follows the done state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised without a finished request");

endmodule

/* verif/tb_ordered_array_list_engine.sv */
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;
    import oal_pkg::*;

    localparam int RANDOM_REQUESTS  = 400;
    localparam int FULL_VISITS_WANT = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 160;
    localparam int CYCLE_LIMIT      = 400000;

    localparam data_t VAL_MIN = 32'h8000_0000;
    localparam data_t VAL_MAX = 32'h7fff_ffff;

    // shadow copy of the list and the queue of results it predicts
    class list_scoreboard;
        typedef struct packed {
            status_t   status;
            data_t     read_value;
            position_t found_position;
            count_t    list_length;
        } list_result_t;

        data_t        slots[CAPACITY];
        int           fill;
        int           errors;
        list_result_t expected_q[$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            $display("%0t ns: %s", $time, what);
            errors++;
        endtask

        // apply one accepted request to the shadow list and queue its result
        function void note_request(opcode_t op, position_t pos, data_t val);
            list_result_t res;
            int           p;
            res = '0;
            p   = pos;
            case (op)
                OP_INSERT:
                begin
                    if (p < 1 || p > fill + 1)
                        res.status = ST_BAD_POSITION;
                    else if (fill >= CAPACITY)
                        res.status = ST_FULL;
                    else
                    begin
                        for (int k = fill; k >= p; k--)
                            slots[k] = slots[k - 1];
                        slots[p - 1] = val;
                        fill++;
                    end
                end
                OP_DELETE:
                begin
                    if (p < 1 || p > fill)
                        res.status = ST_BAD_POSITION;
                    else
                    begin
                        for (int k = p; k < fill; k++)
                            slots[k - 1] = slots[k];
                        fill--;
                    end
                end
                OP_GET:
                begin
                    if (p < 1 || p > fill)
                        res.status = ST_BAD_POSITION;
                    else
                        res.read_value = slots[p - 1];
                end
                default:
                begin
                    // lowest matching position wins
                    for (int k = 0; k < fill; k++)
                    begin
                        if (slots[k] == val)
                        begin
                            res.found_position = position_t'(k + 1);
                            break;
                        end
                    end
                end
            endcase
            res.list_length = count_t'(fill);
            expected_q.push_back(res);
        endfunction

        // compare one result against the oldest prediction
        task check_result(status_t st, data_t rv, position_t fp, count_t len);
            list_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with no request pending: status %0d length %0d",
                                 st, len));
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.status)
                report($sformatf("status %0d, expected %0d", st, want.status));
            if (rv !== want.read_value)
                report($sformatf("read_value %0d, expected %0d", rv, want.read_value));
            if (fp !== want.found_position)
                report($sformatf("found_position %0d, expected %0d", fp,
                                 want.found_position));
            if (len !== want.list_length)
                report($sformatf("list_length %0d, expected %0d", len, want.list_length));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    oal_req_if req_ch();
    oal_rsp_if rsp_ch();

    list_scoreboard sb;

    int tx_idle_pct   = 14;
    int rx_idle_pct   = 48;
    bit long_hold_due = 1'b0;
    int full_visits   = 0;
    int cycle_count   = 0;

    ordered_array_list_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ordered_array_list_engine: mismatch");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.status, rsp_ch.read_value, rsp_ch.found_position,
                            rsp_ch.list_length);
    end

    // result side ready, with one long hold-off on demand
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_due)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_due = 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // offer one request and wait for it to be taken; returns at a falling edge
    task automatic send_request(opcode_t op, position_t pos, data_t val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.position   <= pos;
        req_ch.item_value <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(op, pos, val);
        @(negedge clk);
    endtask

    // values biased toward stored entries and a small pool so locate hits
    function automatic data_t pick_value(int n);
        int roll;
        roll = $urandom_range(99);
        if (roll < 35 && n > 0)
            return sb.slots[$urandom_range(n - 1)];
        if (roll < 70)
            return data_t'($urandom_range(8)) - 4;
        if (roll < 75)
            return ($urandom_range(1) != 0) ? VAL_MIN : VAL_MAX;
        return data_t'($urandom);
    endfunction

    // one random request: mostly well-formed, biased to grow or shrink the list
    task automatic send_random_request(bit grow);
        int        roll;
        int        n;
        opcode_t   op;
        position_t pos;
        data_t     val;
        n   = sb.fill;
        val = pick_value(n);
        if ($urandom_range(99) < 8)
        begin
            // noise: any opcode at any position
            op  = opcode_t'($urandom_range(3));
            pos = position_t'($urandom_range(255));
            val = data_t'($urandom);
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < (grow ? 70 : 25))
            begin
                op  = OP_INSERT;
                pos = position_t'($urandom_range(n + 1, 1));
            end
            else
            begin
                if (roll < (grow ? 78 : 70))
                    op = OP_DELETE;
                else if (roll < (grow ? 89 : 85))
                    op = OP_GET;
                else
                    op = OP_LOCATE;
                if (op == OP_LOCATE)
                    pos = position_t'($urandom_range(255));
                else if (n == 0)
                    pos = 1;
                else
                    pos = position_t'($urandom_range(n, 1));
            end
        end
        send_request(op, pos, val);
    endtask

    task automatic run_directed();
        // empty list: out-of-range positions and a locate that finds nothing
        send_request(OP_GET, 1, 0);
        send_request(OP_DELETE, 0, 0);
        send_request(OP_LOCATE, 0, 0);
        send_request(OP_INSERT, 0, 5);
        send_request(OP_INSERT, 2, 5);
        // build 0, -1, min, max, 7 with front, middle and end inserts
        send_request(OP_INSERT, 1, VAL_MIN);
        send_request(OP_INSERT, 2, VAL_MAX);
        send_request(OP_INSERT, 1, 0);
        send_request(OP_INSERT, 2, -1);
        send_request(OP_INSERT, 5, 7);
        send_request(OP_INSERT, 7, 1);
        send_request(OP_INSERT, 255, 1);
        // reads at both ends and past the end, item_value ignored
        send_request(OP_GET, 1, -1);
        send_request(OP_GET, 3, 0);
        send_request(OP_GET, 5, VAL_MAX);
        send_request(OP_GET, 6, 0);
        send_request(OP_GET, 255, 0);
        // duplicate value: locate gives the lowest position, position ignored
        send_request(OP_INSERT, 4, -1);
        send_request(OP_LOCATE, 255, -1);
        send_request(OP_LOCATE, 0, VAL_MAX);
        send_request(OP_LOCATE, 3, 12345);
        // delete middle, last, past the end and first
        send_request(OP_DELETE, 2, 99);
        send_request(OP_DELETE, 5, 0);
        send_request(OP_DELETE, 5, 0);
        send_request(OP_DELETE, 1, 0);
        send_request(OP_LOCATE, 1, -1);
    endtask

    // random phases: fill to capacity, bounce off full, drain back down
    task automatic run_random();
        int sent;
        bit grow;
        sent = 0;
        grow = 1'b1;
        while (sent < RANDOM_REQUESTS || full_visits < FULL_VISITS_WANT)
        begin
            if (sent == RANDOM_REQUESTS / 3)
            begin
                tx_idle_pct = 48;
                rx_idle_pct = 14;
            end
            if (sent == 2 * RANDOM_REQUESTS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                // hold off results while requests keep coming
                req_ch.valid <= 1'b0;
                @(posedge clk);
                long_hold_due = 1'b1;
                @(negedge clk);
            end
            send_random_request(grow);
            sent++;
            if (sb.fill == CAPACITY)
                full_visits++;
            if (grow && full_visits >= FULL_VISITS_WANT)
                grow = 1'b0;
            else if (!grow && sb.fill == 0)
                grow = 1'b1;
        end
    endtask

    // reset, stimulus and end of run
    initial
    begin
        sb                = new();
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = OP_INSERT;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random();
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("ordered_array_list_engine: match");
        else
            $display("ordered_array_list_engine: mismatch");
        $finish;
    end

endmodule
